[hw/rtl/nmt_pkg.sv]
// Package with the types and constants shared by the named mutex table.
package nmt_pkg;

	localparam int SlotCountDef = 16;
	localparam int WaitDepthDef = 8;
	localparam int ProcessIdsDef = 256;

	typedef enum logic [1:0] {
		REQ_OPEN   = 2'd0,
		REQ_CLOSE  = 2'd1,
		REQ_LOCK   = 2'd2,
		REQ_UNLOCK = 2'd3
	} req_e_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_OPEN  = 2'd1,
		ST_FULL      = 2'd2,
		ST_WAIT_FULL = 2'd3
	} status_e_t;

	localparam logic [2:0] EV_ACK      = 3'd0;
	localparam logic [2:0] EV_GRANTED  = 3'd1;
	localparam logic [2:0] EV_BLOCKED  = 3'd2;
	localparam logic [2:0] EV_WOKEN    = 3'd3;
	localparam logic [2:0] EV_RELEASED = 3'd4;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [63:0] name_tag;
		logic [3:0]  slot_key;
		logic [7:0]  caller_id;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [2:0] event_res;
		logic [3:0] slot_out;
		logic [7:0] process_out;
		logic       last;
	} res_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SCAN,
		BK_EXEC,
		BK_READ,
		BK_EMIT,
		BK_DRAIN
	} bk_state_t;

endpackage

[hw/rtl/nmt_front.sv]
// Front part: takes requests, reduces the caller id and queues them for the back part.
module nmt_front #(
	parameter int PROCESS_IDS = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  nmt_pkg::req_t req_in,
	output logic          req_valid,
	input  logic          req_take,
	output nmt_pkg::req_t req_out
);
	import nmt_pkg::*;

	localparam int Depth = 2;

	// Every 8-bit caller id folded into the id range, worked out at elaboration.
	function automatic logic [2047:0] mod_table();
		logic [2047:0] t;
		for (int i = 0; i < 256; i++)
			t[i*8 +: 8] = 8'(i % PROCESS_IDS);
		return t;
	endfunction

	localparam logic [2047:0] ModTable = mod_table();

	req_t       buf_q [Depth];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	req_t       cooked;

	always_comb begin
		cooked = req_in;
		cooked.caller_id = ModTable[{req_in.caller_id, 3'b000} +: 8];
	end

	assign full = (cnt_q == 2'(Depth));
	assign req_valid = (cnt_q != 2'd0);
	assign req_out = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full)
			buf_q[wr_q] <= cooked;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full)
				wr_q <= ~wr_q;
			if (req_valid && req_take)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(req_valid && req_take);
		end
	end
endmodule

[hw/rtl/nmt_back.sv]
// Back part: the slot table, the waiter memory and the sequencer that carries out requests.
module nmt_back #(
	parameter int SLOT_COUNT = 16,
	parameter int WAIT_DEPTH = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_take,
	input  nmt_pkg::req_t req_in,
	output logic          res_valid,
	input  logic          res_take,
	output nmt_pkg::res_t res_out
);
	import nmt_pkg::*;

	localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int WW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
	localparam int CW = $clog2(WAIT_DEPTH + 1);
	localparam int MW = SW + WW;
	localparam int KW = (SW > 4) ? SW : 4;
	// Each slot owns a power-of-two block of the waiter memory.
	localparam int WaitEntries = SLOT_COUNT * (1 << WW);

	logic [SLOT_COUNT-1:0] open_q, locked_q;
	logic [63:0]           tag_mem [SLOT_COUNT];
	logic [7:0]            wait_mem [WaitEntries];
	logic [WW-1:0]         head_q [SLOT_COUNT];
	logic [CW-1:0]         count_q [SLOT_COUNT];

	bk_state_t   state_q, state_d;
	req_t        req_q;
	logic [SW-1:0] idx_q;
	logic [63:0] tag_rd_q;
	logic [7:0]  wait_rd_q;
	logic        rd_en;
	logic [MW-1:0] rd_addr;
	logic        scan_last;

	// Result register: one result waits here while the sequencer holds.
	res_t res_q;
	logic res_full_q;
	logic res_load;
	res_t res_d;

	assign res_valid = res_full_q;
	assign res_out = res_q;

	logic [KW-1:0] key_ext;
	logic          key_ok;
	logic [SW-1:0] key_s;
	assign key_ext = KW'(req_q.slot_key);
	assign key_ok = (32'(key_ext) < SLOT_COUNT) && open_q[key_s];
	assign key_s = SW'(key_ext);
	assign scan_last = (32'(idx_q) == SLOT_COUNT - 1);

	logic [WW-1:0] head_s, tail_s, head_nx;
	logic [CW-1:0] cnt_s;
	logic [WW:0]   tail_sum;
	assign head_s = head_q[key_s];
	assign cnt_s = count_q[key_s];
	assign tail_sum = (WW+1)'(head_s) + (WW+1)'(cnt_s);
	assign tail_s = (tail_sum >= (WW+1)'(WAIT_DEPTH)) ?
		WW'(tail_sum - (WW+1)'(WAIT_DEPTH)) : WW'(tail_sum);
	assign head_nx = (32'(head_s) == WAIT_DEPTH - 1) ? '0 : head_s + WW'(1);

	assign rd_addr = {key_s, head_s};

	always_ff @(posedge clk) begin
		tag_rd_q <= tag_mem[idx_q];
		if (rd_en)
			wait_rd_q <= wait_mem[rd_addr];
	end

	logic tag_wr, wait_wr;
	always_ff @(posedge clk) begin
		if (tag_wr)
			tag_mem[idx_q] <= req_q.name_tag;
		if (wait_wr)
			wait_mem[{key_s, tail_s}] <= req_q.caller_id;
	end

	// Table updates decided by the sequencer.
	logic claim, do_lock, do_unlock_free, do_pop, do_close, do_push;

	always_comb begin
		state_d = state_q;
		req_take = 1'b0;
		res_load = 1'b0;
		res_d = '0;
		rd_en = 1'b0;
		tag_wr = 1'b0;
		wait_wr = 1'b0;
		claim = 1'b0;
		do_lock = 1'b0;
		do_unlock_free = 1'b0;
		do_pop = 1'b0;
		do_close = 1'b0;
		do_push = 1'b0;
		res_d.slot_out = req_q.slot_key;
		res_d.last = 1'b1;
		case (state_q)
			BK_IDLE: begin
				req_take = req_valid;
				if (req_valid)
					state_d = (req_in.req_type == REQ_OPEN) ? BK_SCAN : BK_EXEC;
			end
			BK_SCAN: begin
				// Tag of idx_q is read through a register here, ready in BK_READ.
				state_d = BK_READ;
			end
			BK_READ: begin
				if (!res_full_q || res_take) begin
					res_d.slot_out = 4'(idx_q);
					if (!open_q[idx_q]) begin
						claim = 1'b1;
						tag_wr = 1'b1;
						res_load = 1'b1;
						state_d = BK_IDLE;
					end else if (tag_rd_q == req_q.name_tag) begin
						res_load = 1'b1;
						state_d = BK_IDLE;
					end else if (scan_last) begin
						res_d.status = ST_FULL;
						res_d.slot_out = 4'd0;
						res_load = 1'b1;
						state_d = BK_IDLE;
					end else begin
						state_d = BK_SCAN;
					end
				end
			end
			BK_EXEC: begin
				if (!res_full_q || res_take) begin
					if (!key_ok) begin
						res_d.status = ST_NOT_OPEN;
						res_load = 1'b1;
						state_d = BK_IDLE;
					end else begin
						case (req_q.req_type)
							REQ_LOCK: begin
								res_load = 1'b1;
								state_d = BK_IDLE;
								if (!locked_q[key_s]) begin
									do_lock = 1'b1;
									res_d.event_res = EV_GRANTED;
								end else if (32'(cnt_s) < WAIT_DEPTH) begin
									wait_wr = 1'b1;
									do_push = 1'b1;
									res_d.event_res = EV_BLOCKED;
									res_d.process_out = req_q.caller_id;
								end else begin
									res_d.status = ST_WAIT_FULL;
								end
							end
							REQ_UNLOCK: begin
								if (cnt_s != '0) begin
									rd_en = 1'b1;
									state_d = BK_EMIT;
								end else begin
									do_unlock_free = 1'b1;
									res_d.event_res = EV_RELEASED;
									res_load = 1'b1;
									state_d = BK_IDLE;
								end
							end
							default: begin
								// Close drains waiters one at a time through BK_DRAIN, then acks.
								if (cnt_s != '0) begin
									rd_en = 1'b1;
									state_d = BK_DRAIN;
								end else begin
									do_close = 1'b1;
									res_load = 1'b1;
									state_d = BK_IDLE;
								end
							end
						endcase
					end
				end
			end
			BK_EMIT: begin
				if (!res_full_q || res_take) begin
					do_pop = 1'b1;
					do_lock = 1'b1;
					res_d.event_res = EV_WOKEN;
					res_d.process_out = wait_rd_q;
					res_load = 1'b1;
					state_d = BK_IDLE;
				end
			end
			BK_DRAIN: begin
				if (!res_full_q || res_take) begin
					do_pop = 1'b1;
					res_d.event_res = EV_WOKEN;
					res_d.process_out = wait_rd_q;
					res_d.last = 1'b0;
					res_load = 1'b1;
					state_d = BK_EXEC;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (req_take)
			req_q <= req_in;
		if (res_load)
			res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			idx_q <= '0;
			res_full_q <= 1'b0;
			open_q <= '0;
			locked_q <= '0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				head_q[i] <= '0;
				count_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (res_load)
				res_full_q <= 1'b1;
			else if (res_take)
				res_full_q <= 1'b0;
			if (req_take)
				idx_q <= '0;
			else if (state_q == BK_READ && state_d == BK_SCAN)
				idx_q <= idx_q + SW'(1);
			if (claim) begin
				open_q[idx_q] <= 1'b1;
				locked_q[idx_q] <= 1'b0;
				head_q[idx_q] <= '0;
				count_q[idx_q] <= '0;
			end
			if (do_lock)
				locked_q[key_s] <= 1'b1;
			if (do_unlock_free)
				locked_q[key_s] <= 1'b0;
			if (do_push)
				count_q[key_s] <= cnt_s + CW'(1);
			if (do_pop) begin
				head_q[key_s] <= head_nx;
				count_q[key_s] <= cnt_s - CW'(1);
			end
			if (do_close) begin
				open_q[key_s] <= 1'b0;
				head_q[key_s] <= '0;
			end
		end
	end
endmodule

[hw/rtl/named_mutex_table_with_fifo_waiters.sv]
// Top level of the named mutex table with FIFO wait queues.
// Requests enter a two-entry queue and are carried out one at a time by a
// sequencer over the slot table. Lock, unlock on a free queue and requests to
// a closed slot are settled in BK_EXEC; unlock with a waiter goes on to
// BK_EMIT, as the waiter is read from a registered memory. Open walks the
// table one slot at a time through BK_SCAN and BK_READ, for the registered
// tag read. Close gives one result per waiter, each through BK_DRAIN for the
// waiter memory read, plus a final ack. A result register holds the next
// result while the caller has not popped it.
module named_mutex_table_with_fifo_waiters #(
	parameter int SLOT_COUNT = nmt_pkg::SlotCountDef,
	parameter int WAIT_DEPTH = nmt_pkg::WaitDepthDef,
	parameter int PROCESS_IDS = nmt_pkg::ProcessIdsDef
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  nmt_pkg::req_t req,
	output logic          empty,
	input  logic          pop,
	output nmt_pkg::res_t res
);
	import nmt_pkg::*;

	logic q_valid, q_take, r_valid;
	req_t q_req;

	nmt_front #(.PROCESS_IDS(PROCESS_IDS)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req_in(req),
		.req_valid(q_valid), .req_take(q_take), .req_out(q_req)
	);

	nmt_back #(.SLOT_COUNT(SLOT_COUNT), .WAIT_DEPTH(WAIT_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .req_valid(q_valid), .req_take(q_take),
		.req_in(q_req), .res_valid(r_valid), .res_take(pop), .res_out(res)
	);

	assign empty = !r_valid;
endmodule

[tb/nmt_checker.sv]
// Checker that predicts the mutex table results and compares them with the block.
module nmt_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic          full,
	input  nmt_pkg::req_t req,
	input  logic          empty,
	input  logic          pop,
	input  nmt_pkg::res_t res,
	output int            fail_count,
	output int            pending
);
	import nmt_pkg::*;

	localparam int SLOTS = SlotCountDef;
	localparam int DEPTH = WaitDepthDef;

	logic        open_flag [SLOTS];
	logic        lock_flag [SLOTS];
	logic [63:0] tag_mem [SLOTS];
	logic [7:0]  waiters [SLOTS][DEPTH];
	int          head [SLOTS];
	int          count [SLOTS];
	res_t        expected_results [$];

	task automatic report(input string what, input res_t got, input res_t want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
		fail_count++;
	endtask

	function automatic res_t make_res(input status_e_t st, input logic [2:0] ev,
			input logic [3:0] slot, input logic [7:0] proc, input logic lst);
		res_t r;
		r.status = st;
		r.event_res = ev;
		r.slot_out = slot;
		r.process_out = proc;
		r.last = lst;
		return r;
	endfunction

	function automatic logic [7:0] take_waiter(input int s);
		logic [7:0] id;
		id = waiters[s][head[s]];
		head[s] = (head[s] + 1) % DEPTH;
		count[s]--;
		return id;
	endfunction

	task automatic predict_request(input req_t r);
		int s;
		int pos;
		if (r.req_type == REQ_OPEN) begin
			for (s = 0; s < SLOTS && open_flag[s]; s++) begin
				if (tag_mem[s] == r.name_tag) begin
					expected_results.push_back(make_res(ST_OK, EV_ACK, 4'(s), 8'd0, 1'b1));
					return;
				end
			end
			if (s >= SLOTS) begin
				expected_results.push_back(make_res(ST_FULL, EV_ACK, 4'd0, 8'd0, 1'b1));
				return;
			end
			open_flag[s] = 1;
			lock_flag[s] = 0;
			tag_mem[s] = r.name_tag;
			head[s] = 0;
			count[s] = 0;
			expected_results.push_back(make_res(ST_OK, EV_ACK, 4'(s), 8'd0, 1'b1));
			return;
		end
		s = int'(r.slot_key);
		if (s >= SLOTS || !open_flag[s]) begin
			expected_results.push_back(make_res(ST_NOT_OPEN, EV_ACK, r.slot_key, 8'd0,
				1'b1));
			return;
		end
		case (r.req_type)
			REQ_CLOSE: begin
				while (count[s] > 0)
					expected_results.push_back(make_res(ST_OK, EV_WOKEN, 4'(s),
						take_waiter(s), 1'b0));
				head[s] = 0;
				open_flag[s] = 0;
				expected_results.push_back(make_res(ST_OK, EV_ACK, 4'(s), 8'd0, 1'b1));
			end
			REQ_LOCK: begin
				if (!lock_flag[s]) begin
					lock_flag[s] = 1;
					expected_results.push_back(make_res(ST_OK, EV_GRANTED, 4'(s), 8'd0,
						1'b1));
				end else if (count[s] < DEPTH) begin
					pos = (head[s] + count[s]) % DEPTH;
					waiters[s][pos] = r.caller_id;
					count[s]++;
					expected_results.push_back(make_res(ST_OK, EV_BLOCKED, 4'(s),
						r.caller_id, 1'b1));
				end else begin
					expected_results.push_back(make_res(ST_WAIT_FULL, EV_ACK, 4'(s), 8'd0,
						1'b1));
				end
			end
			default: begin
				if (count[s] > 0) begin
					lock_flag[s] = 1;
					expected_results.push_back(make_res(ST_OK, EV_WOKEN, 4'(s),
						take_waiter(s), 1'b1));
				end else begin
					lock_flag[s] = 0;
					expected_results.push_back(make_res(ST_OK, EV_RELEASED, 4'(s), 8'd0,
						1'b1));
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			fail_count = 0;
			expected_results.delete();
			for (int i = 0; i < SLOTS; i++) begin
				open_flag[i] = 0;
				lock_flag[i] = 0;
				head[i] = 0;
				count[i] = 0;
			end
			pending = 0;
		end else begin
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					report("unexpected result", res, '0);
				end else begin
					want = expected_results.pop_front();
					if (res.status !== want.status)
						report("status", res, want);
					if (res.event_res !== want.event_res)
						report("event", res, want);
					if (res.slot_out !== want.slot_out)
						report("slot", res, want);
					if (res.process_out !== want.process_out)
						report("process", res, want);
					if (res.last !== want.last)
						report("last", res, want);
				end
			end
			if (push && !full)
				predict_request(req);
			pending = expected_results.size();
		end
	end

endmodule

[tb/tb_top.sv]
// Top of the mutex table testbench: stimulus, idling phases and the verdict.
module tb_top;
	import nmt_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic full;
	req_t req = '0;
	logic empty;
	logic pop = 0;
	res_t res;
	int   fail_count;
	int   pending;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	int   idle_cycles = 0;
	logic [63:0] tag_pool [4];

	named_mutex_table_with_fifo_waiters dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req(req),
		.empty(empty), .pop(pop), .res(res)
	);

	nmt_checker checker_i (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req(req),
		.empty(empty), .pop(pop), .res(res), .fail_count(fail_count),
		.pending(pending)
	);

	always #5 clk = ~clk;

	always @(negedge clk)
		pop <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// Push stays high into the next request when there is no gap between them.
	task automatic send_request(input req_e_t kind, input logic [63:0] tag,
			input logic [3:0] slot, input logic [7:0] caller);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 0;
			@(negedge clk);
		end
		push <= 1;
		req <= '{req_type: kind, name_tag: tag, slot_key: slot, caller_id: caller};
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	task automatic send_random;
		int pick;
		logic [63:0] tag;
		pick = $urandom_range(99);
		tag = (pick < 80) ? tag_pool[$urandom_range(3)] : {$urandom, $urandom};
		if (pick < 20)
			send_request(REQ_OPEN, tag, 4'($urandom), 8'($urandom));
		else if (pick < 30)
			send_request(REQ_CLOSE, tag, 4'($urandom_range(5)), 8'($urandom));
		else if (pick < 70)
			send_request(REQ_LOCK, tag, 4'($urandom_range(5)), 8'($urandom));
		else if (pick < 95)
			send_request(REQ_UNLOCK, tag, 4'($urandom_range(5)), 8'($urandom));
		else
			send_request(req_e_t'($urandom_range(3)), {$urandom, $urandom},
				4'($urandom), 8'($urandom));
	endtask

	initial begin
		int drain;
		tag_pool[0] = 64'h0;
		tag_pool[1] = '1;
		tag_pool[2] = 64'hA5A5_5A5A_F00D_1234;
		tag_pool[3] = 64'h5A5A_A5A5_0FF2_EDCB;
		repeat (6) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		// Directed: closed slots, a hole in the scan, full wait queue and drain.
		send_request(REQ_LOCK, 0, 4'hF, 8'hFF);
		send_request(REQ_UNLOCK, 0, 0, 0);
		send_request(REQ_CLOSE, 0, 4'h7, 0);
		send_request(REQ_OPEN, 64'h0, 0, 0);
		send_request(REQ_OPEN, '1, 0, 0);
		send_request(REQ_OPEN, '1, 0, 0);
		send_request(REQ_LOCK, 0, 0, 8'h00);
		for (int i = 0; i < 9; i++)
			send_request(REQ_LOCK, 0, 0, (i == 0) ? 8'hFF : 8'(16 + i));
		send_request(REQ_UNLOCK, 0, 0, 0);
		send_request(REQ_CLOSE, 0, 0, 0);
		send_request(REQ_OPEN, '1, 0, 0);
		send_request(REQ_OPEN, 64'h1234, 0, 0);
		send_request(REQ_UNLOCK, 0, 1, 0);
		for (int i = 0; i < 15; i++)
			send_request(REQ_OPEN, {$urandom, $urandom}, 0, 0);
		send_request(REQ_OPEN, 64'h77, 0, 0);
		push <= 0;
		wait (pending == 0);
		for (int i = 0; i < 16; i++)
			send_request(REQ_CLOSE, 0, 4'(i), 0);
		push <= 0;
		wait (pending == 0);
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 56 : 26) : 0;
			recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 56 : 26) : 0;
			for (int i = 0; i < 20; i++)
				send_random();
			// Hold the sender until the table has answered everything.
			push <= 0;
			wait (pending == 0);
		end
		recv_stall_pct = 0;
		drain = 0;
		while (pending != 0 && drain < WATCHDOG_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending == 0 && drain < WATCHDOG_LIMIT)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/nmt_pkg.sv
hw/rtl/nmt_front.sv
hw/rtl/nmt_back.sv
hw/rtl/named_mutex_table_with_fifo_waiters.sv
tb/nmt_checker.sv
tb/tb_top.sv
